// ===== rtl/vna_pkg.sv =====
// Shared types and constants of the vertex normal accumulator.
`timescale 1ns / 1ps
`default_nettype none
package vna_pkg;

  localparam int IDX_W      = 10;
  localparam int VERT_COUNT = 1 << IDX_W;
  localparam int POS_W      = 16;
  localparam int NRM_W      = 16;
  localparam int EDGE_W     = POS_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int WIDE_W     = 36;
  localparam int FRAC_BITS  = 14;
  localparam int ENTRY_W    = 3 * POS_W;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } corner_e;

  typedef enum logic {
    SRC_FACE = 1'b0,
    SRC_SUM  = 1'b1
  } norm_src_e;

  typedef struct packed {
    logic      capture;
    logic      pos_rd;
    logic      pos_we;
    logic      nrm_rd;
    logic      nrm_we;
    logic      nrm_wr_zero;
    corner_e   addr_sel;
    logic      latch_en;
    corner_e   latch_sel;
    logic      mul_en;
    logic [2:0] mul_sel;
    logic      norm_start;
    norm_src_e norm_src;
    logic      fn_latch;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/vna_norm.sv =====
// Sequential vector normaliser: shift scaling, bit-serial square root and division.
`timescale 1ns / 1ps
`default_nettype none
module vna_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [vna_pkg::WIDE_W-1:0] vec_i [3],
  output logic                              done_o,
  output logic signed [vna_pkg::NRM_W-1:0]  res_o [3]
);

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIV,
    N_DONE
  } state_e;

  localparam logic [vna_pkg::NRM_W-1:0] NrmOne = vna_pkg::NRM_W'(1 << vna_pkg::FRAC_BITS);

  state_e                             state_q;
  logic [vna_pkg::WIDE_W-1:0]         mag_q [3];
  logic [vna_pkg::WIDE_W-1:0]         big_q;
  logic                               neg_q [3];
  logic [59:0]                        sq_q;
  logic [61:0]                        sum_q;
  logic [34:0]                        rem_q;
  logic [30:0]                        root_q;
  logic [46:0]                        rq_q;
  logic [46:0]                        dv_q;
  logic [15:0]                        quo_q;
  logic [4:0]                         cnt_q;
  logic [1:0]                         comp_q;
  logic signed [vna_pkg::NRM_W-1:0]   res_q [3];

  logic [vna_pkg::WIDE_W-1:0] mag_in [3];
  logic [vna_pkg::WIDE_W-1:0] big_in;
  logic [29:0]                sq_op;
  logic [34:0]                rem_w;
  logic [34:0]                trial;
  logic                       sq_ge;
  logic [46:0]                num;
  logic                       div_ge;
  logic [15:0]                quo_nx;
  logic [15:0]                quo_cl;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec_i[i][vna_pkg::WIDE_W-1] ? vna_pkg::WIDE_W'(-vec_i[i])
                                              : vna_pkg::WIDE_W'(vec_i[i]);
    end
    big_in = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
    if (mag_in[2] > big_in) begin
      big_in = mag_in[2];
    end
    sq_op  = (cnt_q[1:0] == 2'd3) ? 30'd0 : mag_q[cnt_q[1:0]][29:0];
    rem_w  = {rem_q[32:0], sum_q[61:60]};
    trial  = {2'b00, root_q, 2'b01};
    sq_ge  = (rem_w >= trial);
    num    = {3'b000, mag_q[comp_q][29:0], {vna_pkg::FRAC_BITS{1'b0}}}
           + {17'd0, root_q[30:1]};
    div_ge = (rq_q >= dv_q);
    quo_nx = {quo_q[14:0], div_ge};
    quo_cl = (quo_nx > NrmOne) ? NrmOne : quo_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      big_q   <= '0;
      sq_q    <= '0;
      sum_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      rq_q    <= '0;
      dv_q    <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      comp_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= '0;
        neg_q[i] <= 1'b0;
        res_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        N_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_in[i];
              neg_q[i] <= vec_i[i][vna_pkg::WIDE_W-1];
              res_q[i] <= '0;
            end
            big_q   <= big_in;
            state_q <= (big_in == '0) ? N_DONE : N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (|big_q[vna_pkg::WIDE_W-1:30]) begin
            big_q <= big_q >> 1;
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] >> 1;
            end
          end else if (!big_q[29]) begin
            big_q <= big_q << 1;
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] << 1;
            end
          end else begin
            sq_q    <= '0;
            sum_q   <= '0;
            cnt_q   <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          sq_q  <= 60'(sq_op) * 60'(sq_op);
          sum_q <= sum_q + {2'b00, sq_q};
          if (cnt_q == 5'd3) begin
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= N_SQRT;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        N_SQRT: begin
          rem_q  <= sq_ge ? (rem_w - trial) : rem_w;
          root_q <= {root_q[29:0], sq_ge};
          sum_q  <= {sum_q[59:0], 2'b00};
          if (cnt_q == 5'd30) begin
            cnt_q   <= '0;
            comp_q  <= '0;
            state_q <= N_DIV;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        N_DIV: begin
          if (cnt_q == 5'd0) begin
            rq_q  <= num;
            dv_q  <= {1'b0, root_q, 15'd0};
            quo_q <= '0;
            cnt_q <= 5'd1;
          end else begin
            rq_q  <= div_ge ? (rq_q - dv_q) : rq_q;
            dv_q  <= dv_q >> 1;
            quo_q <= quo_nx;
            if (cnt_q == 5'd16) begin
              res_q[comp_q] <= neg_q[comp_q] ? -$signed(quo_cl) : $signed(quo_cl);
              cnt_q         <= '0;
              if (comp_q == 2'd2) begin
                state_q <= N_DONE;
              end else begin
                comp_q <= comp_q + 2'd1;
              end
            end else begin
              cnt_q <= cnt_q + 5'd1;
            end
          end
        end
        N_DONE: begin
          state_q <= N_IDLE;
        end
        default: begin
          state_q <= N_IDLE;
        end
      endcase
    end
  end

  assign done_o = (state_q == N_DONE);
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == N_IDLE)
    else $error("normaliser started while busy");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_q[0] <= $signed(NrmOne)) && (res_q[0] >= -$signed(NrmOne))
            && (res_q[1] <= $signed(NrmOne)) && (res_q[1] >= -$signed(NrmOne))
            && (res_q[2] <= $signed(NrmOne)) && (res_q[2] >= -$signed(NrmOne)))
    else $error("normalised component out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/vna_dp.sv =====
// Datapath: vertex stores, edge cross product, normaliser and result register.
`timescale 1ns / 1ps
`default_nettype none
module vna_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vna_pkg::dp_cmd_t                  cmd_i,
  output vna_pkg::dp_status_t               status_o,
  input  logic [vna_pkg::IDX_W-1:0]         index_a_i,
  input  logic [vna_pkg::IDX_W-1:0]         index_b_i,
  input  logic [vna_pkg::IDX_W-1:0]         index_c_i,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_z_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_z_o
);

  logic [vna_pkg::ENTRY_W-1:0] pos_mem [vna_pkg::VERT_COUNT];
  logic [vna_pkg::ENTRY_W-1:0] nrm_mem [vna_pkg::VERT_COUNT];

  logic [vna_pkg::IDX_W-1:0]          idx_a_q, idx_b_q, idx_c_q;
  logic [vna_pkg::ENTRY_W-1:0]        pos_in_q;
  logic [vna_pkg::ENTRY_W-1:0]        pos_rd_q;
  logic [vna_pkg::ENTRY_W-1:0]        nrm_rd_q;
  logic signed [vna_pkg::POS_W-1:0]   va_q [3];
  logic signed [vna_pkg::POS_W-1:0]   vb_q [3];
  logic signed [vna_pkg::POS_W-1:0]   vc_q [3];
  logic signed [vna_pkg::PROD_W-1:0]  mul_q;
  logic                               mul_vld_q;
  logic [2:0]                         mul_sel_q;
  logic signed [vna_pkg::WIDE_W-1:0]  face_q [3];
  logic signed [vna_pkg::NRM_W-1:0]   fn_q [3];
  logic [vna_pkg::ENTRY_W-1:0]        out_q;
  logic                               out_valid_q;

  logic [vna_pkg::IDX_W-1:0]          addr;
  logic signed [vna_pkg::EDGE_W-1:0]  e1 [3];
  logic signed [vna_pkg::EDGE_W-1:0]  e2 [3];
  logic signed [vna_pkg::EDGE_W-1:0]  op_a, op_b;
  logic signed [vna_pkg::WIDE_W-1:0]  norm_vec [3];
  logic signed [vna_pkg::NRM_W-1:0]   norm_res [3];
  logic                               norm_done;
  logic signed [vna_pkg::NRM_W-1:0]   rd_comp [3];
  logic [vna_pkg::ENTRY_W-1:0]        nrm_wdata;

  always_comb begin
    unique case (cmd_i.addr_sel)
      vna_pkg::SEL_A: addr = idx_a_q;
      vna_pkg::SEL_B: addr = idx_b_q;
      vna_pkg::SEL_C: addr = idx_c_q;
      default:        addr = idx_a_q;
    endcase
    for (int i = 0; i < 3; i++) begin
      e1[i]      = vna_pkg::EDGE_W'(vb_q[i]) - vna_pkg::EDGE_W'(va_q[i]);
      e2[i]      = vna_pkg::EDGE_W'(vc_q[i]) - vna_pkg::EDGE_W'(va_q[i]);
      rd_comp[i] = $signed(nrm_rd_q[vna_pkg::ENTRY_W-1-vna_pkg::NRM_W*i -: vna_pkg::NRM_W]);
      if (cmd_i.norm_src == vna_pkg::SRC_FACE) begin
        norm_vec[i] = face_q[i];
      end else begin
        norm_vec[i] = vna_pkg::WIDE_W'(vna_pkg::EDGE_W'(rd_comp[i])
                                       + vna_pkg::EDGE_W'(fn_q[i]));
      end
    end
    case (cmd_i.mul_sel)
      3'd0:    begin op_a = e1[1]; op_b = e2[2]; end
      3'd1:    begin op_a = e1[2]; op_b = e2[1]; end
      3'd2:    begin op_a = e1[2]; op_b = e2[0]; end
      3'd3:    begin op_a = e1[0]; op_b = e2[2]; end
      3'd4:    begin op_a = e1[0]; op_b = e2[1]; end
      3'd5:    begin op_a = e1[1]; op_b = e2[0]; end
      default: begin op_a = '0;    op_b = '0;    end
    endcase
    nrm_wdata = cmd_i.nrm_wr_zero ? '0 : {norm_res[0], norm_res[1], norm_res[2]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_we) begin
      pos_mem[addr] <= pos_in_q;
    end
    if (cmd_i.pos_rd) begin
      pos_rd_q <= pos_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nrm_we) begin
      nrm_mem[addr] <= nrm_wdata;
    end
    if (cmd_i.nrm_rd) begin
      nrm_rd_q <= nrm_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_a_q  <= index_a_i;
      idx_b_q  <= index_b_i;
      idx_c_q  <= index_c_i;
      pos_in_q <= {pos_x_i, pos_y_i, pos_z_i};
    end
    if (cmd_i.latch_en) begin
      for (int i = 0; i < 3; i++) begin
        case (cmd_i.latch_sel)
          vna_pkg::SEL_A: va_q[i] <= $signed(pos_rd_q[vna_pkg::ENTRY_W-1-vna_pkg::POS_W*i -: vna_pkg::POS_W]);
          vna_pkg::SEL_B: vb_q[i] <= $signed(pos_rd_q[vna_pkg::ENTRY_W-1-vna_pkg::POS_W*i -: vna_pkg::POS_W]);
          default:        vc_q[i] <= $signed(pos_rd_q[vna_pkg::ENTRY_W-1-vna_pkg::POS_W*i -: vna_pkg::POS_W]);
        endcase
      end
    end
    mul_q     <= op_a * op_b;
    mul_sel_q <= cmd_i.mul_sel;
    if (mul_vld_q) begin
      if (mul_sel_q[0]) begin
        face_q[mul_sel_q[2:1]] <= face_q[mul_sel_q[2:1]] - vna_pkg::WIDE_W'(mul_q);
      end else begin
        face_q[mul_sel_q[2:1]] <= vna_pkg::WIDE_W'(mul_q);
      end
    end
    if (cmd_i.fn_latch) begin
      fn_q <= norm_res;
    end
    if (cmd_i.out_load) begin
      out_q <= nrm_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_vld_q <= cmd_i.mul_en;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  vna_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .res_o   (norm_res)
  );

  assign status_o.norm_done = norm_done;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = $signed(out_q[3*vna_pkg::NRM_W-1 -: vna_pkg::NRM_W]);
  assign normal_y_o  = $signed(out_q[2*vna_pkg::NRM_W-1 -: vna_pkg::NRM_W]);
  assign normal_z_o  = $signed(out_q[vna_pkg::NRM_W-1 -: vna_pkg::NRM_W]);

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_wr_after_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.nrm_we && !cmd_i.nrm_wr_zero) |-> norm_done)
    else $error("normal written without a finished normalisation");
`endif

endmodule
`default_nettype wire

// ===== rtl/vna_ctrl.sv =====
// Controller: sequences load, read and triangle commands over the datapath.
`timescale 1ns / 1ps
`default_nettype none
module vna_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          command_i,
  output logic                in_ready_o,
  input  vna_pkg::dp_status_t status_i,
  output vna_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RDREQ,
    S_RDOUT,
    S_TRA,
    S_TRB,
    S_TRC,
    S_TLC,
    S_MUL,
    S_MWAIT,
    S_FNORM,
    S_FWAIT,
    S_CRD,
    S_CSUM,
    S_CWAIT
  } state_e;

  state_e            state_q;
  logic [2:0]        cnt_q;
  vna_pkg::corner_e  corner_q;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_LOAD: begin
        cmd_o.pos_we      = 1'b1;
        cmd_o.nrm_we      = 1'b1;
        cmd_o.nrm_wr_zero = 1'b1;
        cmd_o.addr_sel    = vna_pkg::SEL_A;
      end
      S_RDREQ: begin
        cmd_o.nrm_rd   = 1'b1;
        cmd_o.addr_sel = vna_pkg::SEL_A;
      end
      S_RDOUT: begin
        cmd_o.out_load = !status_i.out_busy;
      end
      S_TRA: begin
        cmd_o.pos_rd   = 1'b1;
        cmd_o.addr_sel = vna_pkg::SEL_A;
      end
      S_TRB: begin
        cmd_o.pos_rd    = 1'b1;
        cmd_o.addr_sel  = vna_pkg::SEL_B;
        cmd_o.latch_en  = 1'b1;
        cmd_o.latch_sel = vna_pkg::SEL_A;
      end
      S_TRC: begin
        cmd_o.pos_rd    = 1'b1;
        cmd_o.addr_sel  = vna_pkg::SEL_C;
        cmd_o.latch_en  = 1'b1;
        cmd_o.latch_sel = vna_pkg::SEL_B;
      end
      S_TLC: begin
        cmd_o.latch_en  = 1'b1;
        cmd_o.latch_sel = vna_pkg::SEL_C;
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_q;
      end
      S_MWAIT: begin
      end
      S_FNORM: begin
        cmd_o.norm_start = 1'b1;
        cmd_o.norm_src   = vna_pkg::SRC_FACE;
      end
      S_FWAIT: begin
        cmd_o.fn_latch = status_i.norm_done;
      end
      S_CRD: begin
        cmd_o.nrm_rd   = 1'b1;
        cmd_o.addr_sel = corner_q;
      end
      S_CSUM: begin
        cmd_o.norm_start = 1'b1;
        cmd_o.norm_src   = vna_pkg::SRC_SUM;
      end
      S_CWAIT: begin
        cmd_o.norm_src = vna_pkg::SRC_SUM;
        cmd_o.nrm_we   = status_i.norm_done;
        cmd_o.addr_sel = corner_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      corner_q <= vna_pkg::SEL_A;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (command_i)
              vna_pkg::CMD_LOAD: state_q <= S_LOAD;
              vna_pkg::CMD_TRI:  state_q <= S_TRA;
              vna_pkg::CMD_READ: state_q <= S_RDREQ;
              default:           state_q <= S_IDLE;
            endcase
          end
        end
        S_LOAD:  state_q <= S_IDLE;
        S_RDREQ: state_q <= S_RDOUT;
        S_RDOUT: begin
          if (!status_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        S_TRA: state_q <= S_TRB;
        S_TRB: state_q <= S_TRC;
        S_TRC: state_q <= S_TLC;
        S_TLC: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (cnt_q == 3'd5) begin
            state_q <= S_MWAIT;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_MWAIT: state_q <= S_FNORM;
        S_FNORM: state_q <= S_FWAIT;
        S_FWAIT: begin
          if (status_i.norm_done) begin
            corner_q <= vna_pkg::SEL_A;
            state_q  <= S_CRD;
          end
        end
        S_CRD:  state_q <= S_CSUM;
        S_CSUM: state_q <= S_CWAIT;
        S_CWAIT: begin
          if (status_i.norm_done) begin
            unique case (corner_q)
              vna_pkg::SEL_A: begin
                corner_q <= vna_pkg::SEL_B;
                state_q  <= S_CRD;
              end
              vna_pkg::SEL_B: begin
                corner_q <= vna_pkg::SEL_C;
                state_q  <= S_CRD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && cnt_q != 3'd5) |=> (state_q == S_MUL && cnt_q == $past(cnt_q) + 3'd1))
    else $error("cross product sequence broken");
`endif

endmodule
`default_nettype wire

// ===== rtl/vertex_normal_accumulator.sv =====
// Top level of the vertex normal accumulator.
`timescale 1ns / 1ps
`default_nettype none
// Holds 1024 vertex positions (signed Q8.8) and per-vertex normals (signed Q1.14) in
// two single-port memories. A load transfer writes a position and clears its normal. A
// read transfer reads the stored normal into a read register and moves it into the
// result register once that register is free or being taken. A triangle transfer runs
// four normalisations. The face normal and the three corner updates each run through
// one shared normaliser, which scales the vector one bit a cycle, squares the
// components, takes a square root one bit a cycle and divides each component one
// quotient bit a cycle; a zero vector skips these steps and gives a zero result.
// One transfer is worked on at a time; the result register lets the next transfer in
// while a normal waits to be taken.
// Stores are not cleared at reset: read or use only vertices that were loaded.
module vertex_normal_accumulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [vna_pkg::IDX_W-1:0]         index_a_i,
  input  logic [vna_pkg::IDX_W-1:0]         index_b_i,
  input  logic [vna_pkg::IDX_W-1:0]         index_c_i,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0]  pos_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0]  normal_z_o
);

  vna_pkg::dp_cmd_t    dp_cmd;
  vna_pkg::dp_status_t dp_status;

  vna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  vna_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .index_a_i   (index_a_i),
    .index_b_i   (index_b_i),
    .index_c_i   (index_c_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o)
  );

endmodule
`default_nettype wire
